>>> rtl/skut_pkg.sv
// skut_pkg: types, codes and sizing constants for the sorted unique key table
// no dependencies; imported by every module of the block but skut_ram
`timescale 1ns / 1ps

package skut_pkg;

    // table size and derived widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // field widths of the transaction payloads
    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 34;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // input transaction
    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic                 ok;
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] found_payload;
        logic [COUNT_W-1:0]   count;
    } out_item_t;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // record store access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    // key compare outcome
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

>>> rtl/skut_ram.sv
// skut_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module skut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/skut_cmp.sv
// skut_cmp: the shared key comparator used by every scan step
// depends on skut_pkg
`timescale 1ns / 1ps

module skut_cmp
    import skut_pkg::*;
(
    input  logic [KEY_W-1:0] stored_key,
    input  logic [KEY_W-1:0] search_key,
    output cmp_res_t         res
);

    // unsigned magnitude compare of a stored key against the search key
    assign res.lt = (stored_key < search_key);
    assign res.eq = (stored_key == search_key);

endmodule

>>> rtl/skut_ctrl.sv
// skut_ctrl: sequencer that scans the record store, shifts records and builds results
// depends on skut_pkg; drives the record store and reads the shared comparator
`timescale 1ns / 1ps

module skut_ctrl
    import skut_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output ram_req_t  ram_req,
    input  entry_t    rd_data,
    input  cmp_res_t  cmp_res,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_data
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,
        S_SCAN_CMP = 9'b000000100,
        S_DECIDE   = 9'b000001000,
        S_INS_RD   = 9'b000010000,
        S_INS_WR   = 9'b000100000,
        S_REM_RD   = 9'b001000000,
        S_REM_WR   = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic [FUNC_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [PAYLOAD_W-1:0]  pay_reg, pay_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  hit_reg, hit_next;
    logic                  ok_reg, ok_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [PAYLOAD_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]      idx_dec;
    logic [CNT_W-1:0]      idx_inc;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign idx_dec = idx_reg - CNT_W'(1);
    assign idx_inc = idx_reg + CNT_W'(1);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        ok_reg     <= ok_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        hit_next    = hit_reg;
        ok_next     = ok_reg;
        status_next = status_reg;
        found_next  = found_reg;
        ram_req     = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = in_data.func;
                    key_next    = in_data.key;
                    pay_next    = in_data.payload;
                    ok_next     = 1'b0;
                    status_next = ST_DONE;
                    found_next  = '0;
                    idx_next    = '0;
                    if (in_data.func == FUNC_CLEAR) begin
                        count_next = '0;
                        ok_next    = 1'b1;
                        state_next = S_RESP;
                    end else if (in_data.func == FUNC_INSERT &&
                                 count_reg == CNT_W'(CAPACITY)) begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            // issue a read, or stop at the end of the table
            S_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    pos_next   = idx_reg;
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg[ADDR_W-1:0];
                    state_next      = S_SCAN_CMP;
                end
            end

            // compare the stored key against the search key
            S_SCAN_CMP: begin
                if (cmp_res.lt) begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end else begin
                    pos_next   = idx_reg;
                    hit_next   = cmp_res.eq;
                    found_next = rd_data.payload;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                case (op_reg)
                    FUNC_INSERT: begin
                        if (hit_reg) begin
                            status_next = ST_DUP;
                            state_next  = S_RESP;
                        end else begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                        found_next = '0;
                    end
                    FUNC_REMOVE: begin
                        if (hit_reg) begin
                            idx_next   = pos_reg + CNT_W'(1);
                            state_next = S_REM_RD;
                        end else begin
                            status_next = ST_MISSING;
                            state_next  = S_RESP;
                        end
                        found_next = '0;
                    end
                    FUNC_SEARCH: begin
                        if (hit_reg) begin
                            ok_next = 1'b1;
                        end else begin
                            status_next = ST_MISSING;
                            found_next  = '0;
                        end
                        state_next = S_RESP;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end

            // move records up one place, top first, then drop in the new record
            S_INS_RD: begin
                if (idx_reg == pos_reg) begin
                    ram_req.wr_en           = 1'b1;
                    ram_req.wr_addr         = idx_reg[ADDR_W-1:0];
                    ram_req.wr_data.key     = key_reg;
                    ram_req.wr_data.payload = pay_reg;
                    count_next              = count_reg + CNT_W'(1);
                    ok_next                 = 1'b1;
                    state_next              = S_RESP;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_dec[ADDR_W-1:0];
                    state_next      = S_INS_WR;
                end
            end

            S_INS_WR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_reg[ADDR_W-1:0];
                ram_req.wr_data = rd_data;
                idx_next        = idx_dec;
                state_next      = S_INS_RD;
            end

            // move later records down one place over the removed one
            S_REM_RD: begin
                if (idx_reg == count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = S_RESP;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg[ADDR_W-1:0];
                    state_next      = S_REM_WR;
                end
            end

            S_REM_WR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_dec[ADDR_W-1:0];
                ram_req.wr_data = rd_data;
                idx_next        = idx_inc;
                state_next      = S_REM_RD;
            end

            // hand the result to the output register
            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result fields; count is the entry count cut to the field width
    assign count_ext              = {{COUNT_W{1'b0}}, count_reg};
    assign res_data.ok            = ok_reg;
    assign res_data.status        = status_reg;
    assign res_data.found_payload = found_reg;
    assign res_data.count         = count_ext[COUNT_W-1:0];

endmodule

>>> rtl/sorted_unique_key_table.sv
// sorted_unique_key_table: top level with record store, comparator, sequencer
// and output register; depends on skut_pkg, skut_ram, skut_cmp, skut_ctrl
`timescale 1ns / 1ps
//
// Keeps up to CAPACITY records sorted ascending by a unique 34-bit key, each
// with a 64-bit payload. Each input transaction on s_* carries an operation
// (insert, remove, search, clear) and gives exactly one result transaction on
// m_* with ok, status, the found payload on a hit, and the record count.
//
// Clear, and insert into a full table, go straight to the result. Every
// other operation first scans the records from the lowest until it meets a
// key at or above the given key or the end of the table. A successful
// insert then shifts the records from the insert point upward up one place,
// top first, and writes the new record; a successful remove shifts the later
// records down one place over the removed one. Each scan or shift step reads
// the record store and then uses its registered read data.
// s_ready is high only while the sequencer is idle.
//
// The result sits in an output register; a new transaction is accepted while
// it waits, and a stalled m_ready holds the block only once its next result
// is ready. Reset empties the table and drops any pending result.
//

module sorted_unique_key_table
    import skut_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    ram_req_t  ram_req;
    entry_t    rd_data;
    logic [ENTRY_W-1:0] rd_bits;
    cmp_res_t  cmp_res;
    logic      res_valid;
    logic      res_ready;
    out_item_t res_data;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    logic [KEY_W-1:0] s_data_key_hold;

    // record store
    skut_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_data = entry_t'(rd_bits);

    // shared key comparator
    skut_cmp u_cmp (
        .stored_key (rd_data.key),
        .search_key (s_data_key_hold),
        .res        (cmp_res)
    );

    // sequencer
    skut_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .ram_req   (ram_req),
        .rd_data   (rd_data),
        .cmp_res   (cmp_res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // search key held from the accepted transaction
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s_data_key_hold <= s_data.key;
        end
    end

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/skut_checker.sv
// skut_checker: port-level assertions for the sorted unique key table
// depends on skut_pkg; bound to sorted_unique_key_table
`timescale 1ns / 1ps

module skut_checker
    import skut_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // count never exceeds the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.count <= COUNT_W'(CAPACITY))
        else $error("count above capacity");

    // ok and status agree
    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.ok == (m_data.status == ST_DONE)))
        else $error("ok and status disagree");

    // a payload is reported only on success
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.found_payload != '0) |-> m_data.ok)
        else $error("payload reported on a failed operation");

endmodule

bind sorted_unique_key_table skut_checker u_skut_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
